// File: rtl/ifa_pkg.sv
// Shared types, codes and constants of the integer to ASCII formatter.
package ifa_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int CMD_W      = 2;
    localparam int HEXCNT_W   = 4;
    localparam int CHAR_W     = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SDEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX  = 2'd2;

    // Hex digit count limit
    localparam logic [HEXCNT_W-1:0] HEX_MAX = 4'd8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_F     = 8'h46;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // One BCD digit per nibble, digit 0 is the least significant
    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    // Classified job handed from the front end to the back end
    typedef struct packed {
        logic                is_hex;
        logic                neg;
        logic [VALUE_W-1:0]  mag;
        logic [HEXCNT_W-1:0] hex_cnt;
    } t_job;

    // Nibble to upper-case hex glyph
    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] base;
        base = (nib < 4'd10) ? ASCII_ZERO : (ASCII_A - 8'd10);
        return base + {4'd0, nib};
    endfunction

endpackage

// File: rtl/ifa_if.sv
// Handshake channels of the formatter: command input and character output.
interface ifa_in_if
    import ifa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    logic [HEXCNT_W-1:0] hex_digits;

    modport source (output valid, output cmd, output value, output hex_digits, input ready);
    modport sink   (input valid, input cmd, input value, input hex_digits, output ready);
endinterface

interface ifa_out_if
    import ifa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/ifa_front.sv
// Front end: accepts commands, classifies them and registers a job.
module ifa_front
    import ifa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    ifa_in_if.sink i_in,
    output logic   o_job_valid,
    input  logic   i_job_ready,
    output t_job   o_job
);

    logic                r_valid;
    t_job                r_job;
    logic                w_take;
    logic                w_neg;
    logic                w_emits;
    logic                w_is_hex;
    logic [VALUE_W-1:0]  w_mag;
    logic [HEXCNT_W-1:0] w_hex_cnt;

    // Output stage frees up when empty or when its job moves on
    assign i_in.ready = !r_valid || i_job_ready;
    assign w_take     = i_in.valid && i_in.ready;

    // Classification: sign, magnitude, digit count, whether anything prints
    assign w_is_hex  = (i_in.cmd == CMD_HEX);
    assign w_neg     = (i_in.cmd == CMD_SDEC) && i_in.value[VALUE_W-1];
    assign w_mag     = w_neg ? (VALUE_W'(0) - i_in.value) : i_in.value;
    assign w_hex_cnt = (i_in.hex_digits > HEX_MAX) ? HEX_MAX : i_in.hex_digits;
    assign w_emits   = (i_in.cmd == CMD_SDEC) || (i_in.cmd == CMD_UDEC) ||
                       (w_is_hex && (i_in.hex_digits != '0));

    // Valid flag: silent commands are taken and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= w_emits;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Job payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job.is_hex  <= w_is_hex;
            r_job.neg     <= w_neg;
            r_job.mag     <= w_mag;
            r_job.hex_cnt <= w_hex_cnt;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

// File: rtl/ifa_queue.sv
// Small job queue between the front end and the back end.
module ifa_queue
    import ifa_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    // DEPTH must be 2 or more; the block itself does not enforce it
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// File: rtl/ifa_back.sv
// Back end: double-dabble conversion of decimal jobs and character emission.
module ifa_back
    import ifa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    ifa_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIZE = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_step;
    logic [VALUE_W-1:0] r_bin;
    t_bcd               r_dig;
    logic [3:0]         r_idx;
    logic               r_neg;
    logic               r_ovalid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    t_bcd               w_adj;
    logic [BCD_W-1:0]   w_adj_flat;
    t_bcd               w_shift;
    logic [3:0]         w_top;
    logic               w_slot;
    logic               w_take;

    assign o_job_ready = (r_state == S_IDLE);
    assign w_take      = i_job_valid && o_job_ready;
    assign w_slot      = !r_ovalid || o_out.ready;

    // Double-dabble step: add 3 to digits of 5 or more, then shift a bit in
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
        w_adj_flat = w_adj;
        w_shift    = {w_adj_flat[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    // Index of the most significant non-zero digit, zero if all are zero
    always_comb begin
        w_top = '0;
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (r_dig[i] != 4'd0) begin
                w_top = 4'(i);
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= i_job.is_hex ? S_EMIT : S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        if (!r_neg && (r_idx == 4'd0)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    r_bin  <= i_job.mag;
                    r_neg  <= i_job.neg;
                    r_step <= '0;
                    r_idx  <= i_job.hex_cnt - 4'd1;
                    if (i_job.is_hex) begin
                        r_dig <= {{(BCD_W - VALUE_W){1'b0}}, i_job.mag};
                    end else begin
                        r_dig <= '0;
                    end
                end
            end
            S_CONV: begin
                r_dig  <= w_shift;
                r_bin  <= {r_bin[VALUE_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
            end
            S_SIZE: begin
                r_idx <= w_top;
            end
            S_EMIT: begin
                if (w_slot) begin
                    if (r_neg) begin
                        r_char <= ASCII_MINUS;
                        r_last <= 1'b0;
                        r_neg  <= 1'b0;
                    end else begin
                        r_char <= glyph(r_dig[r_idx]);
                        r_last <= (r_idx == 4'd0);
                        r_idx  <= r_idx - 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

endmodule

// File: rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: front end, job queue, back end.
//
//  channel  | dir | payload                              | transfer
//  ---------+-----+--------------------------------------+---------------------
//  i_in     | in  | cmd[1:0], value[31:0], hex_digits[3:0]| valid & ready
//  o_out    | out | character[7:0], last                  | valid & ready
//
// Decimal items go through double-dabble in the back end (one bit per cycle),
// then a sizing state, then emit up to 11 characters. Hex items skip both.
// Characters leave one per cycle while the output is ready.
// Commands that print nothing are taken by the front end and dropped.
// Synchronous active-low reset clears all control state and empties the queue.
// The front end keeps accepting while the back end stalls, until the queue fills.
module integer_to_ascii_formatter_unit
    import ifa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifa_in_if.sink    i_in,
    ifa_out_if.source o_out
);

    logic w_front_valid;
    logic w_front_ready;
    t_job w_front_job;
    logic w_back_valid;
    logic w_back_ready;
    t_job w_back_job;

    // Front end
    ifa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    // Job queue
    ifa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_job   (w_front_job),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_job    (w_back_job)
    );

    // Back end
    ifa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .i_job       (w_back_job),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // A minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.character == ASCII_MINUS)) |-> !o_out.last)
        else $error("minus sign marked last");

    // A minus sign only opens an item
    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=>
        !(o_out.valid && (o_out.character == ASCII_MINUS)))
        else $error("minus sign inside an item");

    // Only digits, A to F and minus leave the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        ((o_out.character >= ASCII_ZERO) && (o_out.character <= ASCII_NINE)) ||
        ((o_out.character >= ASCII_A) && (o_out.character <= ASCII_F)) ||
        (o_out.character == ASCII_MINUS))
        else $error("unexpected character code");

    // A command that prints nothing leaves no job behind
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready &&
         ((i_in.cmd == CMD_HEX && i_in.hex_digits == '0) ||
          (i_in.cmd != CMD_SDEC && i_in.cmd != CMD_UDEC && i_in.cmd != CMD_HEX)))
        |=> !w_front_valid)
        else $error("silent command produced a job");
`endif

endmodule
